[rtl/urdf_pkg.sv]
// Shared types, constants and CRC function of the register datagram framer.
`timescale 1ns / 1ps
package urdf_pkg;

  localparam logic [7:0] SYNC_CODE = 8'h05;
  localparam logic [7:0] CRC_POLY  = 8'h07;

  // Access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Datagram lengths in bytes
  localparam logic [3:0] LEN_WRITE = 4'd8;
  localparam logic [3:0] LEN_READ  = 4'd4;

  // Register indexes on the configuration port
  localparam logic REG_NODE_ID = 1'b0;

  // Register stages in front of the serializer
  localparam int PIPE_STAGES = 6;

  // One request as it travels down the CRC pipeline
  typedef struct packed {
    logic        kind;
    logic [1:0]  node;
    logic [6:0]  reg_addr;
    logic [31:0] write_data;
    logic [7:0]  crc;
  } stage_t;

  // CRC-8, poly 0x07, data bits enter LSB first, feedback from CRC bit 7
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    int         b;
    c = crc_in;
    d = data_in;
    for (b = 0; b < 8; b++) begin
      fb = c[7] ^ d[0];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

  // CRC after the sync byte alone
  localparam logic [7:0] CRC_AFTER_SYNC = crc8_byte(8'h00, SYNC_CODE);

endpackage

[rtl/urdf_req_if.sv]
// Request channel: one register access per transfer.
`timescale 1ns / 1ps
interface urdf_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [6:0]  reg_addr;
  logic [31:0] write_data;

  modport source (output valid, kind, reg_addr, write_data, input ready);
  modport sink   (input valid, kind, reg_addr, write_data, output ready);
endinterface

[rtl/urdf_byte_if.sv]
// Byte channel: one datagram byte per transfer, last marks the CRC byte.
`timescale 1ns / 1ps
interface urdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, tx_byte, last, input ready);
  modport sink   (input valid, tx_byte, last, output ready);
endinterface

[rtl/uart_register_datagram_framer.sv]
// Register access datagram framer: CRC pipeline and byte serializer.
`timescale 1ns / 1ps
// Usage:
//   req  (sink): one register access per transfer; kind selects a read request
//        (4-byte datagram) or a register write (8-byte datagram).
//   rsp  (source): datagram bytes in wire order: sync 0x05, node address,
//        register address with bit 7 set for writes, data MSB first for writes,
//        and a CRC-8 (poly 0x07) byte flagged by last.
//   APB: register 0 at address 0 holds the 2-bit node address; write it only
//        while no request is in flight.
// Path: a request enters the first of six CRC stages, moves on one stage per
//   cycle while the next stage can take it, and loads the serializer from the
//   sixth.
// Throughput: the serializer sends one byte per cycle while rsp.ready is high;
//   a write is 8 bytes, a read request 4. A frame waiting in the final stage
//   loads in the cycle the last byte transfers, leaving no gap. The six-stage
//   pipeline buffers up to six requests; req.ready drops only when all are full.
// Reset clears all valid bits and the node address; nothing is emitted.
// A stall on rsp holds the current byte and backs up the pipeline, with no
//   loss or repetition.
module uart_register_datagram_framer
  import urdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  urdf_req_if.sink     req,
  urdf_byte_if.source  rsp,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [1:0] node_id;

  stage_t                 pipe      [PIPE_STAGES];
  stage_t                 pipe_next [PIPE_STAGES];
  logic [PIPE_STAGES-1:0] pipe_valid;
  logic [PIPE_STAGES-1:0] take;

  logic [63:0] tx_shift;
  logic [3:0]  tx_cnt;
  logic        ser_free;
  logic        load;
  logic [63:0] frame;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= 2'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_NODE_ID) begin
      node_id <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_NODE_ID) begin
      prdata = {30'd0, node_id};
    end
  end

  // Serializer takes a frame when empty or when its last byte transfers
  assign ser_free = (tx_cnt == 4'd0) || (tx_cnt == 4'd1 && rsp.ready);
  assign load     = pipe_valid[PIPE_STAGES-1] && ser_free;

  // Stage k accepts when empty or when its item moves on
  always_comb begin
    take[PIPE_STAGES-1] = !pipe_valid[PIPE_STAGES-1] || ser_free;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      take[k] = !pipe_valid[k] || take[k+1];
    end
  end

  assign req.ready = take[0];

  // One CRC byte per stage: node, address, then for writes the four data bytes
  always_comb begin
    pipe_next[0].kind       = req.kind;
    pipe_next[0].node       = node_id;
    pipe_next[0].reg_addr   = req.reg_addr;
    pipe_next[0].write_data = req.write_data;
    pipe_next[0].crc        = crc8_byte(CRC_AFTER_SYNC, {6'd0, node_id});

    pipe_next[1]     = pipe[0];
    pipe_next[1].crc = crc8_byte(pipe[0].crc, {pipe[0].kind, pipe[0].reg_addr});

    for (int k = 2; k < PIPE_STAGES; k++) begin
      pipe_next[k] = pipe[k-1];
      if (pipe[k-1].kind == KIND_WRITE) begin
        pipe_next[k].crc = crc8_byte(pipe[k-1].crc,
                             8'(pipe[k-1].write_data >> (8 * (PIPE_STAGES - 1 - k))));
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
    end else begin
      if (take[0]) begin
        pipe_valid[0] <= req.valid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (take[k]) begin
          pipe_valid[k] <= pipe_valid[k-1];
        end
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < PIPE_STAGES; k++) begin
      if (take[k]) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  // Assemble the datagram from the final stage
  always_comb begin
    if (pipe[PIPE_STAGES-1].kind == KIND_WRITE) begin
      frame = {SYNC_CODE, 6'd0, pipe[PIPE_STAGES-1].node,
               KIND_WRITE, pipe[PIPE_STAGES-1].reg_addr,
               pipe[PIPE_STAGES-1].write_data, pipe[PIPE_STAGES-1].crc};
    end else begin
      frame = {SYNC_CODE, 6'd0, pipe[PIPE_STAGES-1].node,
               KIND_READ, pipe[PIPE_STAGES-1].reg_addr,
               pipe[PIPE_STAGES-1].crc, 32'd0};
    end
  end

  // Byte serializer: load a frame, shift one byte per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_cnt <= 4'd0;
    end else if (load) begin
      tx_cnt <= (pipe[PIPE_STAGES-1].kind == KIND_WRITE) ? LEN_WRITE : LEN_READ;
    end else if (rsp.valid && rsp.ready) begin
      tx_cnt <= tx_cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_shift <= frame;
    end else if (rsp.valid && rsp.ready) begin
      tx_shift <= {tx_shift[55:0], 8'd0};
    end
  end

  assign rsp.valid   = (tx_cnt != 4'd0);
  assign rsp.tx_byte = tx_shift[63:56];
  assign rsp.last    = (tx_cnt == 4'd1);

  // Requests back up only when every stage holds one
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (&pipe_valid))
    else $error("request ready dropped with an empty stage");

  // A byte that is not last is followed by another byte of the frame
  a_frame_continues: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && !rsp.last) |=> rsp.valid)
    else $error("datagram ended without a last byte");

  // A new frame opens with the sync byte
  a_frame_starts_sync: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && rsp.last) ##1 rsp.valid |-> rsp.tx_byte == SYNC_CODE)
    else $error("datagram does not start with the sync byte");

  // A stalled final stage holds its item
  a_tail_holds: assert property (@(posedge clk) disable iff (rst)
    (pipe_valid[PIPE_STAGES-1] && !ser_free) |=>
      (pipe_valid[PIPE_STAGES-1] && $stable(pipe[PIPE_STAGES-1])))
    else $error("final stage lost a stalled request");

endmodule
